// ===== sv/rdq_pkg.sv =====
// ============================================================================
// rdq_pkg: shared types and constants for the reversible deque
// Holds the port item types, the operation and status codes, the cell
// operation set and the link type passed between neighboring cells.
// ============================================================================
package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;

    // Operation codes on the mode field
    localparam logic [2:0] MODE_POP_BACK   = 3'd0;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd1;
    localparam logic [2:0] MODE_TOGGLE     = 3'd2;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd3;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd4;

    // Status codes on the result
    localparam logic [1:0] STATUS_POPPED = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_res;
    } result_t;

    // Physical operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_PUSH_BACK,
        OP_POP_BACK
    } cell_op_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic              v;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } cell_link_t;

    // Chain status seen by the control logic
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] back_value;
    } chain_status_t;

endpackage

// ===== sv/rdq_cell.sv =====
// ============================================================================
// rdq_cell: one slot of the deque chain
// Holds one entry of the front-ordered row (a), one entry of the
// back-ordered row (b) and the shared occupied bit.
// ============================================================================
module rdq_cell
    import rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_op_t          op,
    input  logic [DATA_W-1:0] push_value,
    input  cell_link_t        prev_link,
    input  cell_link_t        next_link,
    output cell_link_t        link
);

    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic              v_reg, v_next;
    logic              first_free;

    // This slot is the first empty one past the occupied run
    assign first_free = !v_reg && prev_link.v;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        v_next = v_reg;
        unique case (op)
            OP_PUSH_FRONT:
            begin
                a_next = prev_link.a;
                if (first_free)
                begin
                    b_next = push_value;
                end
                v_next = prev_link.v;
            end
            OP_POP_FRONT:
            begin
                a_next = next_link.a;
                v_next = next_link.v;
            end
            OP_PUSH_BACK:
            begin
                b_next = prev_link.b;
                if (first_free)
                begin
                    a_next = push_value;
                end
                v_next = prev_link.v;
            end
            OP_POP_BACK:
            begin
                b_next = next_link.b;
                v_next = next_link.v;
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign link = '{v: v_reg, a: a_reg, b: b_reg};

endmodule

// ===== sv/rdq_chain.sv =====
// ============================================================================
// rdq_chain: row of deque cells
// Wires each cell to its neighbors and feeds the pushed item in at the
// head of the row; reports the two end values and empty/full.
// ============================================================================
module rdq_chain
    import rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_op_t          op,
    input  logic [DATA_W-1:0] push_value,
    output chain_status_t     status
);

    cell_link_t links     [DEPTH];
    cell_link_t prev_link [DEPTH];
    cell_link_t next_link [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        if (i == 0)
        begin : g_head
            // Head sees the pushed item as an occupied left neighbor
            assign prev_link[i] = '{v: 1'b1, a: push_value, b: push_value};
        end
        else
        begin : g_inner_prev
            assign prev_link[i] = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // Tail sees an empty right neighbor; keep its own data on a shift-in
            assign next_link[i] = '{v: 1'b0, a: links[i].a, b: links[i].b};
        end
        else
        begin : g_inner_next
            assign next_link[i] = links[i+1];
        end

        rdq_cell u_slot (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .push_value (push_value),
            .prev_link  (prev_link[i]),
            .next_link  (next_link[i]),
            .link       (links[i])
        );
    end

    assign status = '{
        empty:       !links[0].v,
        full:        links[DEPTH-1].v,
        front_value: links[0].a,
        back_value:  links[0].b
    };

endmodule

// ===== sv/reversible_deque.sv =====
// ============================================================================
// reversible_deque: double-ended queue with a constant-time reverse flag
// Deque of up to DEPTH signed 32-bit values built as a row of cells, with
// pop/push at either logical end and a flag that swaps the two ends.
// ============================================================================
// Usage:
//   - Command channel: drive item (mode, value) and raise start; the item is
//     taken at the edge where start is high and busy is low. busy is tied
//     low, so a new item may follow on every cycle.
//   - Result channel: a pop, or a push that finds the deque full, yields one
//     result marked by done for exactly one cycle, in the cycle after the item
//     is taken. Toggle, successful pushes and unused mode codes give none.
//     The receiver cannot stall: take the result in the cycle done is high.
//   - Throughput one item per cycle: each cell updates from its neighbors in
//     parallel and both ends sit at the head of the row.
//   - Cells hold the queue twice, row a front-first and row b back-first: a
//     push shifts one row in at the head and appends to the other at the first
//     free cell; a pop shifts one row out and drops the other's last cell.
//   - Reset empties the queue and clears the reverse flag; cell data is kept.
module reversible_deque
    import rdq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    logic          accept;
    logic          rev_reg, rev_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;
    cell_op_t      op;
    chain_status_t chain_st;
    logic          at_back;

    // The block never stalls: every item is taken when start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the logical operation onto the physical ends of the row
    always_comb
    begin
        op          = OP_IDLE;
        rev_next    = rev_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        at_back     = 1'b0;
        if (accept)
        begin
            unique case (item.mode) inside
                MODE_POP_BACK, MODE_POP_FRONT:
                begin
                    // Logical back is the physical back unless reversed
                    at_back   = (item.mode == MODE_POP_BACK) ^ rev_reg;
                    done_next = 1'b1;
                    if (chain_st.empty)
                    begin
                        result_next = '{status: STATUS_EMPTY, value_res: '0};
                    end
                    else
                    begin
                        op          = at_back ? OP_POP_BACK : OP_POP_FRONT;
                        result_next = '{
                            status:    STATUS_POPPED,
                            value_res: at_back ? chain_st.back_value
                                               : chain_st.front_value
                        };
                    end
                end
                MODE_TOGGLE:
                begin
                    rev_next = !rev_reg;
                end
                MODE_PUSH_BACK, MODE_PUSH_FRONT:
                begin
                    at_back = (item.mode == MODE_PUSH_BACK) ^ rev_reg;
                    if (chain_st.full)
                    begin
                        // Drop the push and report it
                        done_next   = 1'b1;
                        result_next = '{status: STATUS_FULL, value_res: '0};
                    end
                    else
                    begin
                        op = at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    end
                end
                default:
                begin
                    // Unused codes: drop without a result
                    op = OP_IDLE;
                end
            endcase
        end
    end

    rdq_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .push_value (item.value),
        .status     (chain_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rev_reg  <= rev_next;
            done_reg <= done_next;
        end
    end

    // Hold the result payload; only done qualifies it
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A pop on an empty queue reports empty in the next cycle
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chain_st.empty &&
         (item.mode == MODE_POP_BACK || item.mode == MODE_POP_FRONT))
        |=> (done && result.status == STATUS_EMPTY))
        else $error("empty pop not reported");

    // A toggle never produces a result
    a_toggle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == MODE_TOGGLE) |=> !done)
        else $error("result after toggle");

    // A pop from a full queue frees a slot
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chain_st.full &&
         (item.mode == MODE_POP_BACK || item.mode == MODE_POP_FRONT))
        |=> !chain_st.full)
        else $error("pop from full queue left it full");

    // A dropped push leaves the queue full
    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chain_st.full &&
         (item.mode == MODE_PUSH_BACK || item.mode == MODE_PUSH_FRONT))
        |=> (chain_st.full && done && result.status == STATUS_FULL))
        else $error("push into full queue changed state");

endmodule

// ===== bench/rdq_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rdq_checker: result predictor and comparator for the reversible deque
// Watches the command and result channels, keeps its own ring, head, count
// and reverse flag, and checks every result against the oldest one owed.
// ============================================================================
module rdq_checker
    import rdq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result,
    output int      mismatches,
    output int      outstanding
);

    localparam int OWED_CAP = 16;

    logic [DATA_W-1:0] ring_copy [DEPTH];
    int                head_ix;
    int                fill_count;
    logic              flipped;
    result_t           owed_ring [OWED_CAP];
    int                owed_wr;
    int                owed_rd;

    initial mismatches = 0;

    // Queue one reply that the block owes.
    task automatic owed_add(input result_t reply);
        if (owed_wr - owed_rd >= OWED_CAP)
        begin
            mismatches++;
            $display("%0t: expected at most %0d owed results, got %0d",
                     $time, OWED_CAP, owed_wr - owed_rd + 1);
        end
        else
        begin
            owed_ring[owed_wr % OWED_CAP] = reply;
            owed_wr++;
        end
    endtask

    // Apply one item to the shadow deque and queue the reply it causes.
    task automatic deque_apply(input item_t it);
        result_t reply;
        logic    at_back;
        int      idx;
        reply.status    = STATUS_POPPED;
        reply.value_res = '0;
        case (it.mode) inside
            MODE_POP_BACK, MODE_POP_FRONT:
            begin
                at_back = (it.mode == MODE_POP_BACK) ^ flipped;
                if (fill_count == 0)
                begin
                    reply.status = STATUS_EMPTY;
                end
                else if (at_back)
                begin
                    idx = (head_ix + fill_count - 1) % DEPTH;
                    reply.value_res = ring_copy[idx];
                    fill_count--;
                end
                else
                begin
                    reply.value_res = ring_copy[head_ix];
                    head_ix = (head_ix + 1) % DEPTH;
                    fill_count--;
                end
                owed_add(reply);
            end
            MODE_TOGGLE:
            begin
                flipped = !flipped;
            end
            MODE_PUSH_BACK, MODE_PUSH_FRONT:
            begin
                at_back = (it.mode == MODE_PUSH_BACK) ^ flipped;
                if (fill_count >= DEPTH)
                begin
                    reply.status = STATUS_FULL;
                    owed_add(reply);
                end
                else if (at_back)
                begin
                    ring_copy[(head_ix + fill_count) % DEPTH] = it.value;
                    fill_count++;
                end
                else
                begin
                    head_ix = (head_ix + DEPTH - 1) % DEPTH;
                    ring_copy[head_ix] = it.value;
                    fill_count++;
                end
            end
            default:
            begin
                // spare codes: drop silently
            end
        endcase
    endtask

    task automatic check_reply(input result_t got);
        result_t want;
        if (owed_wr == owed_rd)
        begin
            mismatches++;
            $display("%0t: expected no result, got status=%0d value_res=%0d",
                     $time, got.status, got.value_res);
        end
        else
        begin
            want = owed_ring[owed_rd % OWED_CAP];
            owed_rd++;
            if (got.status !== want.status || got.value_res !== want.value_res)
            begin
                mismatches++;
                $display("%0t: expected status=%0d value_res=%0d, got status=%0d value_res=%0d",
                         $time, want.status, want.value_res, got.status, got.value_res);
            end
        end
    endtask

    // Check the result first: it belongs to an item taken at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ix    = 0;
            fill_count = 0;
            flipped    = 1'b0;
            owed_wr    = 0;
            owed_rd    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
                check_reply(result);
            if (start && !busy)
                deque_apply(item);
            outstanding <= owed_wr - owed_rd;
        end
    end

endmodule

// ===== bench/tb_reversible_deque.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_reversible_deque: self-checking bench for the reversible deque
// Drives directed corner items, mixed random traffic, a fill past full and
// a short drain from full, with random gaps; a separate checker predicts
// and compares every result.
// ============================================================================
module tb_reversible_deque;
    import rdq_pkg::*;

    // Spare codes on the mode field: the block must ignore them.
    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    int      mismatch_count;
    int      owed_count;
    int      issued;
    bit      no_idle;

    reversible_deque dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    rdq_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .mismatches  (mismatch_count),
        .outstanding (owed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #1ms;
        $display("tb_reversible_deque: errors");
        $finish;
    end

    // Hold the item on the port until the block takes it, then idle for a
    // random gap. Gaps are mostly zero, sometimes short, rarely long;
    // every 64 items a stretch may switch idling off entirely.
    task automatic issue(input logic [2:0] m, input logic [DATA_W-1:0] v);
        item_t nxt;
        int    gap;
        int    r;
        nxt.mode  = m;
        nxt.value = v;
        item  <= nxt;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        issued++;
        if (issued % 64 == 0)
            no_idle = ($urandom_range(3) == 0);
        r = $urandom_range(99);
        if (no_idle || r < 60)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(3, 1);
        else if (r < 97)
            gap = $urandom_range(12, 4);
        else
            gap = $urandom_range(60, 20);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until the checker owes nothing. The first edge
    // lets the count catch up with an item taken at this very edge.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
    endtask

    // Bias values toward the sign and all-ones extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mixed traffic: pushes and pops balance so occupancy wanders near
    // empty, hitting empty pops and wrapping the head pointer both ways.
    function automatic logic [2:0] pick_mixed();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return MODE_PUSH_BACK;
        else if (r < 40)
            return MODE_PUSH_FRONT;
        else if (r < 60)
            return MODE_POP_BACK;
        else if (r < 80)
            return MODE_POP_FRONT;
        else if (r < 92)
            return MODE_TOGGLE;
        else if (r < 95)
            return MODE_SPARE_A;
        else if (r < 98)
            return MODE_SPARE_B;
        else
            return MODE_SPARE_C;
    endfunction

    task automatic run_mixed(input int count);
        repeat (count)
            issue(pick_mixed(), pick_value());
    endtask

    initial
    begin
        int pushes;
        int pops;

        issued  = 0;
        no_idle = 1'b0;
        rst_n   = 1'b0;
        start  <= 1'b0;
        item   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops on both ends, extremes pushed at both ends,
        // pops in normal and reversed order, spare codes, double toggle.
        issue(MODE_POP_BACK,   $urandom);
        issue(MODE_POP_FRONT,  $urandom);
        issue(MODE_PUSH_BACK,  32'h7fff_ffff);
        issue(MODE_PUSH_FRONT, 32'h8000_0000);
        issue(MODE_PUSH_BACK,  32'h0000_0000);
        issue(MODE_PUSH_FRONT, 32'hffff_ffff);
        issue(MODE_POP_FRONT,  $urandom);
        issue(MODE_POP_BACK,   $urandom);
        issue(MODE_TOGGLE,     $urandom);
        issue(MODE_POP_FRONT,  $urandom);
        issue(MODE_PUSH_FRONT, 32'h5555_5555);
        issue(MODE_PUSH_BACK,  32'haaaa_aaaa);
        issue(MODE_POP_BACK,   $urandom);
        issue(MODE_SPARE_A,    32'h1234_5678);
        issue(MODE_SPARE_B,    32'h0000_0000);
        issue(MODE_SPARE_C,    32'hffff_ffff);
        issue(MODE_TOGGLE,     $urandom);
        issue(MODE_POP_BACK,   $urandom);
        issue(MODE_POP_FRONT,  $urandom);
        issue(MODE_POP_FRONT,  $urandom);
        issue(MODE_TOGGLE,     $urandom);
        issue(MODE_TOGGLE,     $urandom);

        // Pause the sender until every owed result is back.
        settle();

        run_mixed(100);

        // Fill: enough pushes to reach full from any occupancy, then spill
        // a few more so full drops show up at either logical end.
        pushes = 0;
        while (pushes < DEPTH + 16)
        begin
            if ($urandom_range(31) == 0)
                issue(MODE_TOGGLE, pick_value());
            else
            begin
                issue($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
                pushes++;
            end
        end
        settle();

        // Drain a little from full at both ends.
        pops = 0;
        while (pops < 40)
        begin
            if ($urandom_range(11) == 0)
                issue(MODE_TOGGLE, pick_value());
            else
            begin
                issue($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, $urandom);
                pops++;
            end
        end

        // Wait out the last results, then idle on to catch any stray result.
        settle();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && owed_count == 0)
            $display("tb_reversible_deque: clean");
        else
            $display("tb_reversible_deque: errors");
        $finish;
    end

endmodule
